[sv/delimited_frame_receiver_core_assert.svh]
// Assertion macros for the frame receiver RTL.
`ifndef DELIMITED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define DELIMITED_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DFR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Next-cycle implication, checked outside reset.
`define DFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

[sv/dfr_pkg.sv]
// Shared constants and types for the delimited frame receiver.
package dfr_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int DATA_W    = 8;
    localparam int CNT_W     = 6;

    localparam logic [DATA_W-1:0] CH_START = 8'h40;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_TERM  = 8'h00;

    // Body count limit: the store keeps at most BUF_DEPTH-1 bytes.
    localparam logic [CNT_W-1:0] BODY_MAX = CNT_W'(BUF_DEPTH - 1);

    // Readout request from the receive side.
    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] len;
    } t_rd_start;

endpackage

[sv/dfr_if.sv]
// Handshake interfaces for the input byte and the result item channels.
interface dfr_in_if;
    logic                      valid;
    logic                      ready;
    logic [dfr_pkg::DATA_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if;
    logic                      valid;
    logic                      ready;
    logic [dfr_pkg::DATA_W-1:0] data_byte;
    logic [dfr_pkg::CNT_W-1:0]  position;
    logic                      last_of_frame;
    logic [dfr_pkg::CNT_W-1:0]  frame_length;

    modport source (output valid, output data_byte, output position,
                    output last_of_frame, output frame_length, input ready);
    modport sink   (input valid, input data_byte, input position,
                    input last_of_frame, input frame_length, output ready);
endinterface

[sv/delimited_frame_receiver_core.sv]
// Input bytes are taken one per cycle while a frame is being received and readout is not busy.
// A completing LF starts readout; the fetch flag, the pending read and then the result register
// are loaded in turn, then results follow one per cycle (n body bytes + terminator) when the sink is ready.
// No input is taken while the readout fetch runs.
// Throughput is set by the single read port of the body store.
// Reset clears the phase, body count, readout control and result valid; the store is not cleared.
`include "delimited_frame_receiver_core_assert.svh"

module delimited_frame_receiver_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dfr_in_if.sink    i_in,
    dfr_out_if.source o_out
);

    // Store write port (receive side) and read port (readout side).
    logic                         ram_we;
    logic [dfr_pkg::ADDR_W-1:0]   ram_waddr;
    logic [dfr_pkg::DATA_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [dfr_pkg::ADDR_W-1:0]   ram_raddr;
    logic [dfr_pkg::DATA_W-1:0]   ram_rdata;

    // Handoff between the receive sequencer and the readout sequencer.
    dfr_pkg::t_rd_start           rd_start;
    logic                         rd_busy;

    // Body byte store; entries are read only after this frame wrote them.
    dfr_ram #(
        .WIDTH (dfr_pkg::DATA_W),
        .DEPTH (dfr_pkg::BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Receive side: stalls input while readout is fetching.
    dfr_rx u_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_busy  (rd_busy),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .o_start (rd_start)
    );

    // Readout side: one read in flight, result register toward the sink.
    dfr_reader u_reader (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rd_start),
        .o_busy  (rd_busy),
        .o_re    (ram_re),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata),
        .o_out   (o_out)
    );

    // A completed frame must put the readout to work next cycle.
    `DFR_ASSERT_NEXT(a_start_busy, rd_start.go, rd_busy)
    // The store is never written while a readout may still need it.
    `DFR_ASSERT_SAME(a_no_write_in_readout, ram_we, !rd_busy)
    // The terminator sits at the frame length.
    `DFR_ASSERT_SAME(a_term_pos, o_out.valid && o_out.last_of_frame,
        o_out.position == o_out.frame_length && o_out.data_byte == dfr_pkg::CH_TERM)
    // Body items always lie below the frame length.
    `DFR_ASSERT_SAME(a_body_pos, o_out.valid && !o_out.last_of_frame,
        o_out.position < o_out.frame_length)

endmodule

[sv/dfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/dfr_rx.sv]
// Receive sequencer: start/body/after-CR phases and store writes.
module dfr_rx (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dfr_in_if.sink                        i_in,
    input  logic                          i_busy,
    output logic                          o_we,
    output logic [dfr_pkg::ADDR_W-1:0]    o_waddr,
    output logic [dfr_pkg::DATA_W-1:0]    o_wdata,
    output dfr_pkg::t_rd_start            o_start
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_AFTER_CR
    } t_phase;

    t_phase                    r_phase;
    logic [dfr_pkg::CNT_W-1:0] r_count;
    logic                      accept;

    assign i_in.ready = !i_busy;
    assign accept     = i_in.valid && !i_busy;

    always_comb begin
        o_we      = accept && (r_phase == PH_BODY) && (i_in.rx_byte != dfr_pkg::CH_CR)
                    && (r_count < dfr_pkg::BODY_MAX);
        o_waddr   = r_count[dfr_pkg::ADDR_W-1:0];
        o_wdata   = i_in.rx_byte;
        o_start.go  = accept && (r_phase == PH_AFTER_CR) && (i_in.rx_byte == dfr_pkg::CH_LF);
        o_start.len = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (accept) begin
            case (r_phase)
                PH_BODY: begin
                    if (i_in.rx_byte == dfr_pkg::CH_CR) begin
                        r_phase <= PH_AFTER_CR;
                    end else if (r_count < dfr_pkg::BODY_MAX) begin
                        r_count <= r_count + dfr_pkg::CNT_W'(1);
                    end
                end
                PH_AFTER_CR: begin
                    // LF or not, the frame is over; the byte never starts a frame
                    r_phase <= PH_IDLE;
                end
                PH_IDLE: begin
                    if (i_in.rx_byte == dfr_pkg::CH_START) begin
                        r_phase <= PH_BODY;
                        r_count <= '0;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/dfr_reader.sv]
// Readout sequencer: fetches stored bytes and drives the result register.
module dfr_reader (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dfr_pkg::t_rd_start            i_start,
    output logic                          o_busy,
    output logic                          o_re,
    output logic [dfr_pkg::ADDR_W-1:0]    o_raddr,
    input  logic [dfr_pkg::DATA_W-1:0]    i_rdata,
    dfr_out_if.source                     o_out
);

    // fetch side
    logic                      r_fetching, n_fetching;
    logic [dfr_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [dfr_pkg::CNT_W-1:0] r_len, n_len;
    // item whose RAM data is on the read port
    logic                      r_pend, n_pend;
    logic [dfr_pkg::CNT_W-1:0] r_pend_pos, n_pend_pos;
    logic                      r_pend_last, n_pend_last;
    // result register
    logic                      r_valid, n_valid;
    logic [dfr_pkg::DATA_W-1:0] r_data, n_data;
    logic [dfr_pkg::CNT_W-1:0] r_pos, n_pos;
    logic                      r_last, n_last;
    logic [dfr_pkg::CNT_W-1:0] r_olen, n_olen;

    logic load;
    logic fetch;

    assign load    = r_pend && (!r_valid || o_out.ready);
    assign fetch   = r_fetching && (!r_pend || load);
    assign o_busy  = r_fetching || r_pend;
    assign o_re    = fetch && (r_idx != r_len);
    assign o_raddr = r_idx[dfr_pkg::ADDR_W-1:0];

    always_comb begin
        n_fetching  = r_fetching;
        n_idx       = r_idx;
        n_len       = r_len;
        n_pend      = r_pend;
        n_pend_pos  = r_pend_pos;
        n_pend_last = r_pend_last;
        n_valid     = r_valid;
        n_data      = r_data;
        n_pos       = r_pos;
        n_last      = r_last;
        n_olen      = r_olen;

        if (load) begin
            n_valid = 1'b1;
            n_data  = r_pend_last ? dfr_pkg::CH_TERM : i_rdata;
            n_pos   = r_pend_pos;
            n_last  = r_pend_last;
            n_olen  = r_len;
            n_pend  = 1'b0;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end

        if (fetch) begin
            n_pend      = 1'b1;
            n_pend_pos  = r_idx;
            n_pend_last = (r_idx == r_len);
            n_idx       = r_idx + dfr_pkg::CNT_W'(1);
            if (r_idx == r_len) begin
                n_fetching = 1'b0;
            end
        end

        if (i_start.go) begin
            n_fetching = 1'b1;
            n_idx      = '0;
            n_len      = i_start.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetching <= 1'b0;
            r_pend     <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_fetching <= n_fetching;
            r_pend     <= n_pend;
            r_valid    <= n_valid;
        end
        r_idx       <= n_idx;
        r_len       <= n_len;
        r_pend_pos  <= n_pend_pos;
        r_pend_last <= n_pend_last;
        r_data      <= n_data;
        r_pos       <= n_pos;
        r_last      <= n_last;
        r_olen      <= n_olen;
    end

    assign o_out.valid         = r_valid;
    assign o_out.data_byte     = r_data;
    assign o_out.position      = r_pos;
    assign o_out.last_of_frame = r_last;
    assign o_out.frame_length  = r_olen;

endmodule
